[rtl/rmq_pkg.sv]
// ---------------------------------------------------------------------------
// rmq_pkg
// Item types, branch codes and per-stage context for the matrix to
// quaternion pipeline.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int DATA_W = 16;
    localparam int NUM_W  = 17;   // difference or sum of two entries
    localparam int LANES  = 4;    // w, x, y, z

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic [1:0]               branch_taken;
        logic                     degenerate;
    } rmq_out_t;

    // context carried through the first root stages
    typedef struct packed {
        branch_t                      branch;
        logic                         deg;
        logic [LANES-1:0][NUM_W-1:0]  num;
    } rmq_ctx_t;

    // context carried after the numerators have been consumed
    typedef struct packed {
        branch_t branch;
        logic    deg;
    } rmq_tag_t;

endpackage

[rtl/rotation_matrix_to_quaternion.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fully pipelined conversion of a 3x3 rotation matrix to a normalised
// quaternion (Shepperd's method), signed fixed point.
// ---------------------------------------------------------------------------
// One item (nine matrix entries) may enter on every clock and one result
// item leaves per clock while m_ready is high. Each item passes through
// four bit-per-stage units in line: the first square root (R_W stages),
// the divides by S (DN1 stages), the square root of the length (L_W
// stages) and the normalising divides (DN2 stages). The whole pipe
// advances together: when the output register holds an item that is not
// taken, every stage holds and s_ready is low.
// branch_taken gives the diagonal chosen; degenerate flags a non-positive
// root argument or zero length, with zero quaternion fields.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rmq_pkg::rmq_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rmq_pkg::rmq_out_t  m_data
);

    localparam int NW     = rmq_pkg::NUM_W;
    localparam int DW     = rmq_pkg::DATA_W;
    localparam int LN     = rmq_pkg::LANES;
    // root argument: ONE plus an 18-bit signed diagonal sum
    localparam int ARG_W  = ((FRAC_BITS + 1 > 18) ? FRAC_BITS + 1 : 18) + 1;
    localparam int RAD_W0 = ARG_W - 1 + FRAC_BITS;
    localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
    localparam int R_W    = RAD_W / 2;          // first root
    localparam int S_W    = R_W + 1;            // S = 2*root
    localparam int DN1    = NW + FRAC_BITS;     // |num| * ONE, also |q| width
    localparam int Q_W    = DN1;
    localparam int H      = (Q_W + 1) / 2;      // low half for squaring
    localparam int HI_W   = Q_W - H;
    localparam int SQ_W   = 2 * Q_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int L_W    = SUM_W / 2;          // length root
    localparam int DN2    = Q_W + FRAC_BITS;

    localparam logic [ARG_W-1:0] ONE_A = ARG_W'(1) << FRAC_BITS;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // -----------------------------------------------------------------------
    // Stage A: branch choice, root argument, numerators
    // -----------------------------------------------------------------------
    logic signed [17:0]      tr_c;
    logic signed [17:0]      diag_c;
    logic signed [ARG_W-1:0] arg_c;
    logic                    deg_a_c;
    logic [RAD_W-1:0]        rad_a_c;
    rmq_pkg::rmq_ctx_t       ctx_a_c;
    logic signed [NW-1:0]    n_12m21, n_20m02, n_01m10, n_10p01, n_20p02, n_21p12;

    always_comb begin
        tr_c    = 18'(s_data.m00) + 18'(s_data.m11) + 18'(s_data.m22);
        n_12m21 = NW'(s_data.m12) - NW'(s_data.m21);
        n_20m02 = NW'(s_data.m20) - NW'(s_data.m02);
        n_01m10 = NW'(s_data.m01) - NW'(s_data.m10);
        n_10p01 = NW'(s_data.m10) + NW'(s_data.m01);
        n_20p02 = NW'(s_data.m20) + NW'(s_data.m02);
        n_21p12 = NW'(s_data.m21) + NW'(s_data.m12);
        ctx_a_c.num = '0;
        if (tr_c > 0) begin
            ctx_a_c.branch = rmq_pkg::BR_TRACE;
            diag_c         = tr_c;
            ctx_a_c.num[1] = n_12m21;
            ctx_a_c.num[2] = n_20m02;
            ctx_a_c.num[3] = n_01m10;
        end else if (s_data.m00 > s_data.m11 && s_data.m00 > s_data.m22) begin
            ctx_a_c.branch = rmq_pkg::BR_X;
            diag_c         = 18'(s_data.m00) - 18'(s_data.m11) - 18'(s_data.m22);
            ctx_a_c.num[0] = n_12m21;
            ctx_a_c.num[2] = n_10p01;
            ctx_a_c.num[3] = n_20p02;
        end else if (s_data.m11 > s_data.m22) begin
            ctx_a_c.branch = rmq_pkg::BR_Y;
            diag_c         = 18'(s_data.m11) - 18'(s_data.m00) - 18'(s_data.m22);
            ctx_a_c.num[0] = n_20m02;
            ctx_a_c.num[1] = n_10p01;
            ctx_a_c.num[3] = n_21p12;
        end else begin
            ctx_a_c.branch = rmq_pkg::BR_Z;
            diag_c         = 18'(s_data.m22) - 18'(s_data.m11) - 18'(s_data.m00);
            ctx_a_c.num[0] = n_01m10;
            ctx_a_c.num[1] = n_20p02;
            ctx_a_c.num[2] = n_21p12;
        end
        arg_c       = signed'(ONE_A) + ARG_W'(diag_c);
        deg_a_c     = arg_c[ARG_W-1] || (arg_c == '0);
        ctx_a_c.deg = deg_a_c;
        rad_a_c     = deg_a_c ? '0
                              : RAD_W'({arg_c[ARG_W-2:0], {FRAC_BITS{1'b0}}});
    end

    // -----------------------------------------------------------------------
    // First square root: one result bit per stage
    // -----------------------------------------------------------------------
    logic [RAD_W-1:0]  s1_rad_reg  [0:R_W];
    logic [R_W+1:0]    s1_rem_reg  [0:R_W];
    logic [R_W-1:0]    s1_root_reg [0:R_W];
    rmq_pkg::rmq_ctx_t s1_ctx_reg  [0:R_W];
    logic              s1_v_reg    [0:R_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg[0] <= 1'b0;
        end else if (en) begin
            s1_v_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_rad_reg[0]  <= rad_a_c;
            s1_rem_reg[0]  <= '0;
            s1_root_reg[0] <= '0;
            s1_ctx_reg[0]  <= ctx_a_c;
        end
    end

    for (genvar i = 0; i < R_W; i++) begin : g_sq1
        logic [R_W+3:0] t;
        logic [R_W+3:0] trial;
        logic [R_W+3:0] diff;
        logic           ge;

        assign t     = {s1_rem_reg[i], s1_rad_reg[i][RAD_W-1 -: 2]};
        assign trial = {2'b00, s1_root_reg[i], 2'b01};
        assign ge    = t >= trial;
        assign diff  = t - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s1_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                s1_v_reg[i+1] <= s1_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s1_rad_reg[i+1]  <= s1_rad_reg[i] << 2;
                s1_rem_reg[i+1]  <= ge ? diff[R_W+1:0] : t[R_W+1:0];
                s1_root_reg[i+1] <= {s1_root_reg[i][R_W-2:0], ge};
                s1_ctx_reg[i+1]  <= s1_ctx_reg[i];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage C: set up the divides by S
    // -----------------------------------------------------------------------
    logic [LN-1:0][DN1-1:0] c_nq;
    logic [LN-1:0]          c_sgn;
    rmq_pkg::rmq_tag_t      c_tag;

    always_comb begin
        logic signed [NW-1:0] n;
        for (int l = 0; l < LN; l++) begin
            n        = signed'(s1_ctx_reg[R_W].num[l]);
            c_sgn[l] = n[NW-1];
            c_nq[l]  = {(n[NW-1] ? NW'(-n) : NW'(n)), {FRAC_BITS{1'b0}}};
        end
        c_tag.branch = s1_ctx_reg[R_W].branch;
        c_tag.deg    = s1_ctx_reg[R_W].deg || (s1_root_reg[R_W] == '0);
    end

    logic [LN-1:0][DN1-1:0] d1_nq_reg   [0:DN1];
    logic [LN-1:0][S_W-1:0] d1_rem_reg  [0:DN1];
    logic [LN-1:0]          d1_sgn_reg  [0:DN1];
    logic [S_W-1:0]         d1_div_reg  [0:DN1];
    logic [R_W-1:0]         d1_root_reg [0:DN1];
    rmq_pkg::rmq_tag_t      d1_tag_reg  [0:DN1];
    logic                   d1_v_reg    [0:DN1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_v_reg[0] <= 1'b0;
        end else if (en) begin
            d1_v_reg[0] <= s1_v_reg[R_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_nq_reg[0]   <= c_nq;
            d1_rem_reg[0]  <= '0;
            d1_sgn_reg[0]  <= c_sgn;
            d1_div_reg[0]  <= {s1_root_reg[R_W], 1'b0};
            d1_root_reg[0] <= s1_root_reg[R_W];
            d1_tag_reg[0]  <= c_tag;
        end
    end

    // restoring divide, one quotient bit per stage, four lanes
    for (genvar j = 0; j < DN1; j++) begin : g_dv1
        logic [LN-1:0][DN1-1:0] nq_n;
        logic [LN-1:0][S_W-1:0] rem_n;

        always_comb begin
            logic [S_W:0] t;
            logic [S_W:0] diff;
            logic         ge;
            for (int l = 0; l < LN; l++) begin
                t        = {d1_rem_reg[j][l], d1_nq_reg[j][l][DN1-1]};
                diff     = t - {1'b0, d1_div_reg[j]};
                ge       = t >= {1'b0, d1_div_reg[j]};
                rem_n[l] = ge ? diff[S_W-1:0] : t[S_W-1:0];
                nq_n[l]  = {d1_nq_reg[j][l][DN1-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d1_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                d1_v_reg[j+1] <= d1_v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d1_nq_reg[j+1]   <= nq_n;
                d1_rem_reg[j+1]  <= rem_n;
                d1_sgn_reg[j+1]  <= d1_sgn_reg[j];
                d1_div_reg[j+1]  <= d1_div_reg[j];
                d1_root_reg[j+1] <= d1_root_reg[j];
                d1_tag_reg[j+1]  <= d1_tag_reg[j];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage D: pick the components, split squares into partial products
    // -----------------------------------------------------------------------
    logic [LN-1:0][Q_W-1:0]    p_mag_c;
    logic [LN-1:0]             p_sgn_c;
    logic [LN-1:0][2*HI_W-1:0] p_hh_c;
    logic [LN-1:0][HI_W+H-1:0] p_hl_c;
    logic [LN-1:0][2*H-1:0]    p_ll_c;

    always_comb begin
        logic big;
        for (int l = 0; l < LN; l++) begin
            big        = 2'(l) == d1_tag_reg[DN1].branch;
            p_mag_c[l] = big ? Q_W'(d1_root_reg[DN1] >> 1) : d1_nq_reg[DN1][l];
            p_sgn_c[l] = !big && d1_sgn_reg[DN1][l];
            if (d1_tag_reg[DN1].deg) begin
                p_mag_c[l] = '0;
            end
            p_hh_c[l] = p_mag_c[l][Q_W-1:H] * p_mag_c[l][Q_W-1:H];
            p_hl_c[l] = p_mag_c[l][Q_W-1:H] * p_mag_c[l][H-1:0];
            p_ll_c[l] = p_mag_c[l][H-1:0] * p_mag_c[l][H-1:0];
        end
    end

    logic [LN-1:0][Q_W-1:0]    p_mag_reg;
    logic [LN-1:0]             p_sgn_reg;
    logic [LN-1:0][2*HI_W-1:0] p_hh_reg;
    logic [LN-1:0][HI_W+H-1:0] p_hl_reg;
    logic [LN-1:0][2*H-1:0]    p_ll_reg;
    rmq_pkg::rmq_tag_t         p_tag_reg;
    logic                      p_v_reg;

    // Stage E: whole squares
    logic [LN-1:0][SQ_W-1:0]   e_sq_c;
    logic [LN-1:0][SQ_W-1:0]   e_sq_reg;
    logic [LN-1:0][Q_W-1:0]    e_mag_reg;
    logic [LN-1:0]             e_sgn_reg;
    rmq_pkg::rmq_tag_t         e_tag_reg;
    logic                      e_v_reg;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            e_sq_c[l] = (SQ_W'(p_hh_reg[l]) << (2 * H))
                      + (SQ_W'(p_hl_reg[l]) << (H + 1))
                      + SQ_W'(p_ll_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg <= d1_v_reg[DN1];
            e_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_mag_reg <= p_mag_c;
            p_sgn_reg <= p_sgn_c;
            p_hh_reg  <= p_hh_c;
            p_hl_reg  <= p_hl_c;
            p_ll_reg  <= p_ll_c;
            p_tag_reg <= d1_tag_reg[DN1];
            e_sq_reg  <= e_sq_c;
            e_mag_reg <= p_mag_reg;
            e_sgn_reg <= p_sgn_reg;
            e_tag_reg <= p_tag_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage F and length root
    // -----------------------------------------------------------------------
    logic [SUM_W-1:0]       s2_rad_reg  [0:L_W];
    logic [L_W+1:0]         s2_rem_reg  [0:L_W];
    logic [L_W-1:0]         s2_root_reg [0:L_W];
    logic [LN-1:0][Q_W-1:0] s2_mag_reg  [0:L_W];
    logic [LN-1:0]          s2_sgn_reg  [0:L_W];
    rmq_pkg::rmq_tag_t      s2_tag_reg  [0:L_W];
    logic                   s2_v_reg    [0:L_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg[0] <= 1'b0;
        end else if (en) begin
            s2_v_reg[0] <= e_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_rad_reg[0]  <= SUM_W'(e_sq_reg[0]) + SUM_W'(e_sq_reg[1])
                            + SUM_W'(e_sq_reg[2]) + SUM_W'(e_sq_reg[3]);
            s2_rem_reg[0]  <= '0;
            s2_root_reg[0] <= '0;
            s2_mag_reg[0]  <= e_mag_reg;
            s2_sgn_reg[0]  <= e_sgn_reg;
            s2_tag_reg[0]  <= e_tag_reg;
        end
    end

    for (genvar i = 0; i < L_W; i++) begin : g_sq2
        logic [L_W+3:0] t;
        logic [L_W+3:0] trial;
        logic [L_W+3:0] diff;
        logic           ge;

        assign t     = {s2_rem_reg[i], s2_rad_reg[i][SUM_W-1 -: 2]};
        assign trial = {2'b00, s2_root_reg[i], 2'b01};
        assign ge    = t >= trial;
        assign diff  = t - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s2_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                s2_v_reg[i+1] <= s2_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s2_rad_reg[i+1]  <= s2_rad_reg[i] << 2;
                s2_rem_reg[i+1]  <= ge ? diff[L_W+1:0] : t[L_W+1:0];
                s2_root_reg[i+1] <= {s2_root_reg[i][L_W-2:0], ge};
                s2_mag_reg[i+1]  <= s2_mag_reg[i];
                s2_sgn_reg[i+1]  <= s2_sgn_reg[i];
                s2_tag_reg[i+1]  <= s2_tag_reg[i];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage G and normalising divides
    // -----------------------------------------------------------------------
    logic [LN-1:0][DN2-1:0] g_nq_c;
    rmq_pkg::rmq_tag_t      g_tag_c;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            g_nq_c[l] = {s2_mag_reg[L_W][l], {FRAC_BITS{1'b0}}};
        end
        g_tag_c.branch = s2_tag_reg[L_W].branch;
        g_tag_c.deg    = s2_tag_reg[L_W].deg || (s2_root_reg[L_W] == '0);
    end

    logic [LN-1:0][DN2-1:0] d2_nq_reg  [0:DN2];
    logic [LN-1:0][L_W-1:0] d2_rem_reg [0:DN2];
    logic [LN-1:0]          d2_sgn_reg [0:DN2];
    logic [L_W-1:0]         d2_div_reg [0:DN2];
    rmq_pkg::rmq_tag_t      d2_tag_reg [0:DN2];
    logic                   d2_v_reg   [0:DN2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_v_reg[0] <= 1'b0;
        end else if (en) begin
            d2_v_reg[0] <= s2_v_reg[L_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_nq_reg[0]  <= g_nq_c;
            d2_rem_reg[0] <= '0;
            d2_sgn_reg[0] <= s2_sgn_reg[L_W];
            d2_div_reg[0] <= s2_root_reg[L_W];
            d2_tag_reg[0] <= g_tag_c;
        end
    end

    for (genvar j = 0; j < DN2; j++) begin : g_dv2
        logic [LN-1:0][DN2-1:0] nq_n;
        logic [LN-1:0][L_W-1:0] rem_n;

        always_comb begin
            logic [L_W:0] t;
            logic [L_W:0] diff;
            logic         ge;
            for (int l = 0; l < LN; l++) begin
                t        = {d2_rem_reg[j][l], d2_nq_reg[j][l][DN2-1]};
                diff     = t - {1'b0, d2_div_reg[j]};
                ge       = t >= {1'b0, d2_div_reg[j]};
                rem_n[l] = ge ? diff[L_W-1:0] : t[L_W-1:0];
                nq_n[l]  = {d2_nq_reg[j][l][DN2-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d2_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                d2_v_reg[j+1] <= d2_v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d2_nq_reg[j+1]  <= nq_n;
                d2_rem_reg[j+1] <= rem_n;
                d2_sgn_reg[j+1] <= d2_sgn_reg[j];
                d2_div_reg[j+1] <= d2_div_reg[j];
                d2_tag_reg[j+1] <= d2_tag_reg[j];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Output register: sign, saturation, degenerate zeroing
    // -----------------------------------------------------------------------
    logic [LN-1:0][DW-1:0] o_q_c;
    rmq_pkg::rmq_out_t     m_data_next;
    rmq_pkg::rmq_out_t     m_data_reg;
    logic                  m_valid_reg;

    always_comb begin
        logic [DN2-1:0] mag;
        for (int l = 0; l < LN; l++) begin
            mag = d2_nq_reg[DN2][l];
            if (d2_tag_reg[DN2].deg) begin
                o_q_c[l] = '0;
            end else if (d2_sgn_reg[DN2][l]) begin
                o_q_c[l] = (mag > DN2'(32768)) ? 16'h8000 : 16'(16'd0 - mag[DW-1:0]);
            end else begin
                o_q_c[l] = (mag > DN2'(32767)) ? 16'h7fff : mag[DW-1:0];
            end
        end
        m_data_next.quat_w       = signed'(o_q_c[0]);
        m_data_next.quat_x       = signed'(o_q_c[1]);
        m_data_next.quat_y       = signed'(o_q_c[2]);
        m_data_next.quat_z       = signed'(o_q_c[3]);
        m_data_next.branch_taken = d2_tag_reg[DN2].branch;
        m_data_next.degenerate   = d2_tag_reg[DN2].deg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_v_reg[DN2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.degenerate |->
            m_data_reg.quat_w == '0 && m_data_reg.quat_x == '0 &&
            m_data_reg.quat_y == '0 && m_data_reg.quat_z == '0)
        else $error("degenerate item with non-zero quaternion");

    a_trace_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_v_reg[0] && s1_ctx_reg[0].branch == rmq_pkg::BR_TRACE |->
            !s1_ctx_reg[0].deg)
        else $error("trace branch flagged degenerate");

    a_root_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_v_reg[R_W] && !s1_ctx_reg[R_W].deg |-> s1_root_reg[R_W] != '0)
        else $error("zero root from positive argument");

endmodule
